// ----- src/assert_macros.svh -----
// Assertion macros shared by the cubic Bezier point unit RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CBZ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
`define CBZ_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
`else
`define CBZ_ASSERT(label, clk, rst_n, prop, msg)
`define CBZ_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ----- src/cbz_pkg.sv -----
// Shared types and constants of the cubic Bezier point unit.
// No dependencies; imported by the interfaces and all modules but cbz_lerp.
package cbz_pkg;

    localparam int PT_W = 12;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load_p0;
        logic load_p1;
        logic load_p2;
        logic load_p3;
        logic issue;
        logic issue_last;
    } t_dp_cmd;

endpackage

// ----- src/cbz_pt_if.sv -----
// Input channel of the cubic Bezier point unit: command and control point.
// Depends on cbz_pkg for the coordinate width.
interface cbz_pt_if import cbz_pkg::*;;
    logic            valid;
    logic            ready;
    logic            cmd;
    logic [PT_W-1:0] point_x;
    logic [PT_W-1:0] point_y;

    modport source (output valid, output cmd, output point_x, output point_y, input ready);
    modport sink   (input valid, input cmd, input point_x, input point_y, output ready);
endinterface

// ----- src/cbz_crv_if.sv -----
// Output channel of the cubic Bezier point unit: one evaluated curve point.
// Depends on cbz_pkg for the coordinate width.
interface cbz_crv_if import cbz_pkg::*;;
    logic            valid;
    logic            ready;
    logic [PT_W-1:0] curve_x;
    logic [PT_W-1:0] curve_y;
    logic            last;

    modport source (output valid, output curve_x, output curve_y, output last, input ready);
    modport sink   (input valid, input curve_x, input curve_y, input last, output ready);
endinterface

// ----- src/cubic_bezier_de_casteljau_points_unit.sv -----
// Top level of the cubic Bezier point unit (de Casteljau, floored steps).
// Depends on cbz_pkg, cbz_pt_if, cbz_crv_if, cbz_ctrl and cbz_dp.
//
//  Port    Dir  Word                       Notes
//  i_pt    in   cmd, point_x, point_y      add a control point or clear held points
//  o_crv   out  curve_x, curve_y, last     STEPS words per completed segment
//
// Add and clear words are taken while the unit is idle. The fourth point of a segment
// starts a run of STEPS curve points, one entering the interpolation pipeline per
// cycle unless o_crv stalls; input is held off for that run. Each curve word passes
// through six pipeline stages plus the output register on its way to o_crv.
// A stall on o_crv freezes the pipeline and the run. Reset clears only control state.
module cubic_bezier_de_casteljau_points_unit import cbz_pkg::*; #(
    parameter int STEPS      = 64,
    parameter int COORD_BITS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cbz_pt_if.sink     i_pt,
    cbz_crv_if.source  o_crv
);
    localparam int CW = (COORD_BITS < PT_W) ? COORD_BITS : PT_W;
    localparam int KW = $clog2(STEPS);

    t_dp_cmd       w_dp_cmd;
    logic [KW-1:0] w_k;
    logic          w_adv;
    logic          w_ready;

    assign i_pt.ready = w_ready;

    cbz_ctrl #(.STEPS(STEPS)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_pt.valid),
        .i_in_cmd (i_pt.cmd),
        .o_ready  (w_ready),
        .i_adv    (w_adv),
        .o_dp_cmd (w_dp_cmd),
        .o_k      (w_k)
    );

    cbz_dp #(.STEPS(STEPS), .COORD_W(CW)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_dp_cmd),
        .i_k       (w_k),
        .i_point_x (i_pt.point_x),
        .i_point_y (i_pt.point_y),
        .o_adv     (w_adv),
        .o_crv     (o_crv)
    );
endmodule

// ----- src/cbz_lerp.sv -----
// One floored linear interpolation, floor((a*(S-k) + b*k) / S), in two stages.
// Division by S is a multiply by a rounded-up reciprocal; no package needed.
module cbz_lerp #(
    parameter int STEPS   = 64,
    parameter int COORD_W = 12
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [COORD_W-1:0]         i_a,
    input  logic [COORD_W-1:0]         i_b,
    input  logic [$clog2(STEPS)-1:0]   i_k,
    output logic [COORD_W-1:0]         o_q
);
    localparam int L    = $clog2(STEPS);
    localparam int N    = COORD_W + L;
    localparam int SH   = N + L;
    localparam int MW   = N + 1;
    localparam int PW   = N + MW;
    localparam logic [MW-1:0] MULT = MW'((2 ** SH + STEPS - 1) / STEPS);

    logic signed [COORD_W:0] w_d;
    logic signed [N+1:0]     w_dk;
    logic        [N-1:0]     w_as;
    logic signed [N+1:0]     w_sum;
    logic        [N-1:0]     r_num;
    logic        [PW-1:0]    r_prod;

    // Numerator written as a*S + (b-a)*k; it is never negative.
    assign w_d   = $signed({1'b0, i_b}) - $signed({1'b0, i_a});
    assign w_dk  = w_d * $signed({1'b0, i_k});
    assign w_as  = N'(i_a) * N'(STEPS);
    assign w_sum = $signed({2'b00, w_as}) + w_dk;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= w_sum[N-1:0];
            r_prod <= PW'(r_num) * PW'(MULT);
        end
    end

    assign o_q = r_prod[SH +: COORD_W];
endmodule

// ----- src/cbz_ctrl.sv -----
// Controller of the cubic Bezier point unit: held-point count and run sequencer.
// Depends on cbz_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cbz_ctrl import cbz_pkg::*; #(
    parameter int STEPS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     i_in_cmd,
    output logic                     o_ready,
    input  logic                     i_adv,
    output t_dp_cmd                  o_dp_cmd,
    output logic [$clog2(STEPS)-1:0] o_k
);
    localparam int KW = $clog2(STEPS);
    localparam logic [KW-1:0] K_LAST = KW'(STEPS - 1);

    t_state        r_state, n_state;
    logic [1:0]    r_held, n_held;
    logic [KW-1:0] r_k, n_k;
    logic          w_accept;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign o_k      = r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_held  <= 2'd0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_held   = r_held;
        n_k      = r_k;
        o_dp_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_cmd == CMD_CLEAR) begin
                        n_held = 2'd0;
                    end else if (r_held == 2'd0) begin
                        o_dp_cmd.load_p0 = 1'b1;
                        n_held           = 2'd1;
                    end else if (r_held == 2'd1) begin
                        o_dp_cmd.load_p1 = 1'b1;
                        n_held           = 2'd2;
                    end else if (r_held == 2'd2) begin
                        o_dp_cmd.load_p2 = 1'b1;
                        n_held           = 2'd3;
                    end else begin
                        o_dp_cmd.load_p3 = 1'b1;
                        n_state          = ST_RUN;
                        n_k              = '0;
                    end
                end
            end
            ST_RUN: begin
                // One curve point enters the pipeline per cycle unless the output stalls.
                if (i_adv) begin
                    o_dp_cmd.issue = 1'b1;
                    if (r_k == K_LAST) begin
                        o_dp_cmd.issue_last = 1'b1;
                        n_state             = ST_IDLE;
                        n_held              = 2'd1;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `CBZ_ASSERT(a_run_end, i_clk, i_rst_n, o_dp_cmd.issue_last |=> (r_state == ST_IDLE && r_held == 2'd1), "segment run did not return to one held point")
    `CBZ_NEVER(a_k_range, i_clk, i_rst_n, r_state == ST_RUN && r_k > K_LAST, "step index beyond the last step")
    `CBZ_ASSERT(a_run_start, i_clk, i_rst_n, (r_state == ST_RUN && $past(r_state) == ST_IDLE) |-> ($past(r_held) == 2'd3 && r_k == '0), "run started without three held points")
endmodule

// ----- src/cbz_dp.sv -----
// Datapath of the cubic Bezier point unit: held points, three-level
// interpolation pipeline and output register. Depends on cbz_pkg, cbz_lerp,
// cbz_crv_if and assert_macros.svh.
`include "assert_macros.svh"
module cbz_dp import cbz_pkg::*; #(
    parameter int STEPS   = 64,
    parameter int COORD_W = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic [$clog2(STEPS)-1:0] i_k,
    input  logic [PT_W-1:0]          i_point_x,
    input  logic [PT_W-1:0]          i_point_y,
    output logic                     o_adv,
    cbz_crv_if.source                o_crv
);
    localparam int KW    = $clog2(STEPS);
    localparam int DEPTH = 6;

    logic [COORD_W-1:0] r_pt [2][4];
    logic [COORD_W-1:0] w_l1 [2][3];
    logic [COORD_W-1:0] w_l2 [2][2];
    logic [COORD_W-1:0] w_l3 [2];
    logic [DEPTH-1:0]   r_vld;
    logic [DEPTH-1:0]   r_last;
    logic [KW-1:0]      r_kp [4];
    logic               w_adv;
    logic               r_out_valid;
    logic [PT_W-1:0]    r_out_x;
    logic [PT_W-1:0]    r_out_y;
    logic               r_out_last;

    // The whole pipeline moves together; it freezes while a finished word waits.
    assign w_adv = !r_out_valid || o_crv.ready;
    assign o_adv = w_adv;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_p0) begin
            r_pt[0][0] <= i_point_x[COORD_W-1:0];
            r_pt[1][0] <= i_point_y[COORD_W-1:0];
        end else if (i_cmd.issue_last) begin
            // The end point becomes the next segment's anchor.
            r_pt[0][0] <= r_pt[0][3];
            r_pt[1][0] <= r_pt[1][3];
        end
        if (i_cmd.load_p1) begin
            r_pt[0][1] <= i_point_x[COORD_W-1:0];
            r_pt[1][1] <= i_point_y[COORD_W-1:0];
        end
        if (i_cmd.load_p2) begin
            r_pt[0][2] <= i_point_x[COORD_W-1:0];
            r_pt[1][2] <= i_point_y[COORD_W-1:0];
        end
        if (i_cmd.load_p3) begin
            r_pt[0][3] <= i_point_x[COORD_W-1:0];
            r_pt[1][3] <= i_point_y[COORD_W-1:0];
        end
    end

    for (genvar gc = 0; gc < 2; gc++) begin : g_coord
        for (genvar gi = 0; gi < 3; gi++) begin : g_l1
            cbz_lerp #(.STEPS(STEPS), .COORD_W(COORD_W)) u_lerp (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_a   (r_pt[gc][gi]),
                .i_b   (r_pt[gc][gi+1]),
                .i_k   (i_k),
                .o_q   (w_l1[gc][gi])
            );
        end
        for (genvar gi = 0; gi < 2; gi++) begin : g_l2
            cbz_lerp #(.STEPS(STEPS), .COORD_W(COORD_W)) u_lerp (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_a   (w_l1[gc][gi]),
                .i_b   (w_l1[gc][gi+1]),
                .i_k   (r_kp[1]),
                .o_q   (w_l2[gc][gi])
            );
        end
        cbz_lerp #(.STEPS(STEPS), .COORD_W(COORD_W)) u_l3 (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (w_l2[gc][0]),
            .i_b   (w_l2[gc][1]),
            .i_k   (r_kp[3]),
            .o_q   (w_l3[gc])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld       <= {r_vld[DEPTH-2:0], i_cmd.issue};
            r_last      <= {r_last[DEPTH-2:0], i_cmd.issue_last};
            r_out_valid <= r_vld[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_kp[0]    <= i_k;
            r_kp[1]    <= r_kp[0];
            r_kp[2]    <= r_kp[1];
            r_kp[3]    <= r_kp[2];
            r_out_x    <= PT_W'(w_l3[0]);
            r_out_y    <= PT_W'(w_l3[1]);
            r_out_last <= r_last[DEPTH-1];
        end
    end

    assign o_crv.valid   = r_out_valid;
    assign o_crv.curve_x = r_out_x;
    assign o_crv.curve_y = r_out_y;
    assign o_crv.last    = r_out_last;

    `CBZ_ASSERT(a_issue_adv, i_clk, i_rst_n, i_cmd.issue |-> w_adv, "point issued into a frozen pipeline")
    `CBZ_ASSERT(a_freeze, i_clk, i_rst_n, !w_adv |=> $stable(r_vld), "pipeline moved during an output stall")
    `CBZ_NEVER(a_last_vld, i_clk, i_rst_n, (r_last & ~r_vld) != '0, "last mark on an empty pipeline stage")
endmodule

// ----- test/tb_cubic_bezier_de_casteljau_points_unit.sv -----
// Self-checking testbench for the cubic Bezier point unit: directed table, then random points.
// Depends on cbz_pkg, cbz_pt_if, cbz_crv_if and the RTL top level.
module tb_cubic_bezier_de_casteljau_points_unit;
    import cbz_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS        = 64;
    localparam int COORD_BITS   = 12;
    localparam int RANDOM_WORDS = 138;
    localparam int DIR_ROWS     = 22;
    localparam int TAIL_CYCLES  = 24;
    localparam int LONG_HOLD    = 500;
    localparam int MAX_PRINTS   = 30;

    localparam logic [PT_W-1:0] COORD_MASK = PT_W'((1 << COORD_BITS) - 1);
    localparam logic [PT_W-1:0] PT_MAX     = '1;

    typedef struct packed {
        logic [PT_W-1:0] x;
        logic [PT_W-1:0] y;
    } t_coord;

    typedef struct packed {
        logic [PT_W-1:0] x;
        logic [PT_W-1:0] y;
        logic            last;
    } t_curve_word;

    // A row with known_pt set closes a segment whose four points are all equal,
    // so every curve point of the run is that same point.
    typedef struct packed {
        logic            cmd;
        logic [PT_W-1:0] x;
        logic [PT_W-1:0] y;
        logic            known_pt;
        logic [PT_W-1:0] known_x;
        logic [PT_W-1:0] known_y;
    } t_dir_row;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{CMD_CLEAR, 12'hFFF, 12'hABC, 1'b0, 12'h000, 12'h000},
        '{CMD_ADD,   12'h000, 12'h000, 1'b0, 12'h000, 12'h000},
        '{CMD_ADD,   12'h000, 12'h000, 1'b0, 12'h000, 12'h000},
        '{CMD_ADD,   12'h000, 12'h000, 1'b0, 12'h000, 12'h000},
        '{CMD_ADD,   12'h000, 12'h000, 1'b1, 12'h000, 12'h000},
        '{CMD_CLEAR, 12'h000, 12'h000, 1'b0, 12'h000, 12'h000},
        '{CMD_ADD,   12'hFFF, 12'hFFF, 1'b0, 12'h000, 12'h000},
        '{CMD_ADD,   12'hFFF, 12'hFFF, 1'b0, 12'h000, 12'h000},
        '{CMD_ADD,   12'hFFF, 12'hFFF, 1'b0, 12'h000, 12'h000},
        '{CMD_ADD,   12'hFFF, 12'hFFF, 1'b1, 12'hFFF, 12'hFFF},
        '{CMD_ADD,   12'h000, 12'hFFF, 1'b0, 12'h000, 12'h000},
        '{CMD_ADD,   12'hFFF, 12'h000, 1'b0, 12'h000, 12'h000},
        '{CMD_ADD,   12'h000, 12'h000, 1'b0, 12'h000, 12'h000},
        '{CMD_ADD,   12'h800, 12'h123, 1'b0, 12'h000, 12'h000},
        '{CMD_CLEAR, 12'h555, 12'hAAA, 1'b0, 12'h000, 12'h000},
        '{CMD_ADD,   12'h000, 12'h000, 1'b0, 12'h000, 12'h000},
        '{CMD_ADD,   12'hFFF, 12'h000, 1'b0, 12'h000, 12'h000},
        '{CMD_ADD,   12'h000, 12'hFFF, 1'b0, 12'h000, 12'h000},
        '{CMD_ADD,   12'hFFF, 12'hFFF, 1'b0, 12'h000, 12'h000},
        '{CMD_ADD,   12'hAAA, 12'h555, 1'b0, 12'h000, 12'h000},
        '{CMD_ADD,   12'h555, 12'hAAA, 1'b0, 12'h000, 12'h000},
        '{CMD_ADD,   12'h123, 12'hFED, 1'b0, 12'h000, 12'h000}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    cbz_pt_if  pt_ch ();
    cbz_crv_if crv_ch ();

    cubic_bezier_de_casteljau_points_unit #(
        .STEPS      (STEPS),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_ch),
        .o_crv   (crv_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow of the held segment points.
    int unsigned held_pts;
    t_coord      seg_anchor;
    t_coord      seg_ctrl1;
    t_coord      seg_ctrl2;

    t_curve_word pending_pts [$];
    int unsigned words_seen;
    int unsigned err_count;

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        err_count++;
        if (err_count <= MAX_PRINTS) begin
            $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
        end
    endtask

    function automatic logic [PT_W-1:0] lerp_floor(int unsigned a, int unsigned b,
                                                   int unsigned k);
        return PT_W'((a * (STEPS - k) + b * k) / STEPS);
    endfunction

    function automatic t_coord lerp_coord(t_coord a, t_coord b, int unsigned k);
        t_coord r;
        r.x = lerp_floor(a.x, b.x, k);
        r.y = lerp_floor(a.y, b.y, k);
        return r;
    endfunction

    // Updates the held points for one accepted word and, when it closes a segment,
    // queues the STEPS curve points unless the caller supplies them itself.
    function automatic void advance_curve_state(logic cmd, t_coord p, bit queue_pts);
        t_coord      e, f, g, h, m, j;
        t_curve_word w;
        p.x = p.x & COORD_MASK;
        p.y = p.y & COORD_MASK;
        if (cmd == CMD_CLEAR) begin
            held_pts   = 0;
            seg_anchor = '0;
            seg_ctrl1  = '0;
            seg_ctrl2  = '0;
            return;
        end
        case (held_pts)
            0: begin
                seg_anchor = p;
                held_pts   = 1;
            end
            1: begin
                seg_ctrl1 = p;
                held_pts  = 2;
            end
            2: begin
                seg_ctrl2 = p;
                held_pts  = 3;
            end
            default: begin
                if (queue_pts) begin
                    for (int unsigned k = 0; k < STEPS; k++) begin
                        e      = lerp_coord(seg_anchor, seg_ctrl1, k);
                        f      = lerp_coord(seg_ctrl1, seg_ctrl2, k);
                        g      = lerp_coord(seg_ctrl2, p, k);
                        h      = lerp_coord(e, f, k);
                        m      = lerp_coord(f, g, k);
                        j      = lerp_coord(h, m, k);
                        w.x    = j.x;
                        w.y    = j.y;
                        w.last = (k == STEPS - 1);
                        pending_pts.push_back(w);
                    end
                end
                seg_anchor = p;
                held_pts   = 1;
            end
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [PT_W-1:0] pick_coord();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return PT_MAX;
        if (r == 2) return PT_W'($urandom_range(0, 63));
        return PT_W'($urandom());
    endfunction

    // Sender side: optional gap, then one word held until it is taken.
    int unsigned send_burst;

    task automatic send_word(logic cmd, logic [PT_W-1:0] x, logic [PT_W-1:0] y,
                             bit known_pt, logic [PT_W-1:0] kx, logic [PT_W-1:0] ky);
        int unsigned gap;
        t_coord      p;
        t_curve_word w;
        if (send_burst > 0) begin
            send_burst--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 15) == 0) send_burst = $urandom_range(10, 40);
            gap = pick_gap();
        end
        if (gap > 0) begin
            pt_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pt_ch.valid   <= 1'b1;
        pt_ch.cmd     <= cmd;
        pt_ch.point_x <= x;
        pt_ch.point_y <= y;
        do @(posedge i_clk); while (!pt_ch.ready);
        p.x = x;
        p.y = y;
        advance_curve_state(cmd, p, !known_pt);
        if (known_pt) begin
            for (int k = 0; k < STEPS; k++) begin
                w.x    = kx;
                w.y    = ky;
                w.last = (k == STEPS - 1);
                pending_pts.push_back(w);
            end
        end
    endtask

    initial begin
        logic            cmd;
        logic [PT_W-1:0] x, y;
        i_rst_n       <= 1'b0;
        pt_ch.valid   <= 1'b0;
        pt_ch.cmd     <= CMD_ADD;
        pt_ch.point_x <= '0;
        pt_ch.point_y <= '0;
        held_pts   = 0;
        seg_anchor = '0;
        seg_ctrl1  = '0;
        seg_ctrl2  = '0;
        send_burst = 0;
        err_count  = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_word(dir_rows[r].cmd, dir_rows[r].x, dir_rows[r].y,
                      dir_rows[r].known_pt, dir_rows[r].known_x, dir_rows[r].known_y);
        end

        // Mostly well-formed point streams, with a clear now and then to break a segment.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            cmd = ($urandom_range(0, 99) < 6) ? CMD_CLEAR : CMD_ADD;
            x   = pick_coord();
            y   = pick_coord();
            send_word(cmd, x, y, 1'b0, '0, '0);
        end
        pt_ch.valid <= 1'b0;

        while (pending_pts.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Receiver side: random stalls, bursts of steady ready, and one long hold-off
    // that backs the pipeline up into the input.
    initial begin
        int unsigned stall;
        int unsigned burst;
        bit          hold_done;
        crv_ch.ready <= 1'b0;
        burst     = 0;
        hold_done = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!hold_done && words_seen >= 100) begin
                hold_done = 1'b1;
                stall     = LONG_HOLD;
            end else if (burst > 0) begin
                burst--;
                stall = 0;
            end else begin
                if ($urandom_range(0, 15) == 0) burst = $urandom_range(10, 40);
                stall = pick_gap();
            end
            if (stall > 0) begin
                crv_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            crv_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    initial words_seen = 0;

    always @(posedge i_clk) begin
        t_curve_word want;
        if (i_rst_n && crv_ch.valid && crv_ch.ready) begin
            words_seen++;
            if (pending_pts.size() == 0) begin
                report_mismatch("curve word with nothing pending, x", crv_ch.curve_x, 0);
            end else begin
                want = pending_pts.pop_front();
                if (crv_ch.curve_x !== want.x) begin
                    report_mismatch("curve_x", crv_ch.curve_x, want.x);
                end
                if (crv_ch.curve_y !== want.y) begin
                    report_mismatch("curve_y", crv_ch.curve_y, want.y);
                end
                if (crv_ch.last !== want.last) begin
                    report_mismatch("last", crv_ch.last, want.last);
                end
            end
        end
    end

    initial begin
        #(50_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/cbz_pkg.sv
src/cbz_pt_if.sv
src/cbz_crv_if.sv
src/cbz_lerp.sv
src/cbz_ctrl.sv
src/cbz_dp.sv
src/cubic_bezier_de_casteljau_points_unit.sv
test/tb_cubic_bezier_de_casteljau_points_unit.sv
